@@ hw/rtl/tes_pkg.sv @@
`default_nettype none
package tes_pkg;

	localparam int QueueDepthDefault = 16;
	localparam int MaxFire = 16;
	localparam int TimeW = 48;
	localparam int IdW = 32;
	localparam int ClientW = 31;
	localparam int PortW = 16;
	localparam int PeriodW = 24;
	localparam int CountW = 31;
	localparam logic [9:0] UsPerMs = 10'd1000;

	typedef enum logic [1:0] {
		FUNC_ONESHOT = 2'd0,
		FUNC_REPEAT  = 2'd1,
		FUNC_CANCEL  = 2'd2,
		FUNC_TICK    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_FIRED  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_ADD,
		ST_CANCEL,
		ST_SCAN,
		ST_PICK,
		ST_FIRE,
		ST_MUL,
		ST_REARM,
		ST_DONE
	} state_t;

	// control from sequencer to the scan unit
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/tes_scan.sv @@
`default_nettype none
// Walks the slots one per cycle while step is high and keeps a running best candidate.
module tes_scan #(
	parameter int QUEUE_DEPTH = tes_pkg::QueueDepthDefault,
	localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tes_pkg::scan_ctl_t     ctl,
	input  wire logic [SW-1:0]          slot,
	input  wire logic                   cand,
	input  wire logic [tes_pkg::TimeW-1:0] cand_dl,
	output logic                        found,
	output logic [SW-1:0]               best_slot
);
	logic [tes_pkg::TimeW-1:0] best_dl_q;
	logic                      found_q;
	logic [SW-1:0]             best_q;

	// keep strictly earlier deadline; ties keep the lower slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.step && cand && (!found_q || cand_dl < best_dl_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && cand && (!found_q || cand_dl < best_dl_q)) begin
			best_dl_q <= cand_dl;
			best_q <= slot;
		end
	end

	assign found = found_q;
	assign best_slot = best_q;
endmodule
`default_nettype wire

@@ hw/rtl/timer_event_scheduler_top.sv @@
`default_nettype none
// Timer event scheduler: a store of QUEUE_DEPTH pending timers.
// Command channel: drive func and its fields with start high while busy is
// low; the item is taken at that edge. Results come out on kind, timer_id,
// fired_client, fired_port and last, each valid for one cycle with strobe
// high; the receiver cannot hold them off. last marks the final result of
// an item. A quiet tick gives no result.
// An add walks the slots one per cycle to find the lowest free one, and a
// cancel walks them once. A tick does one scan of all slots per fired
// timer (the shared compare unit), then the fire and re-arm multiply, for
// up to 16 fires; a further scan that finds none ends the tick unless the
// cap of 16 fires was reached.
// busy stays high for the whole item; one item at a time.
// Reset clears all valid bits and the id counter; stores are not cleared.
module timer_event_scheduler_top #(
	parameter int QUEUE_DEPTH = tes_pkg::QueueDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [47:0] now_time,
	input  wire logic [47:0] deadline,
	input  wire logic [23:0] period_ms,
	input  wire logic [30:0] repeat_count,
	input  wire logic [30:0] client_id,
	input  wire logic [15:0] dest_port,
	input  wire logic [31:0] cancel_id,
	output logic             strobe,
	output logic [1:0]       kind,
	output logic [31:0]      timer_id,
	output logic [30:0]      fired_client,
	output logic [15:0]      fired_port,
	output logic             last
);
	localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int FW = $clog2(tes_pkg::MaxFire + 1);
	localparam int TW = tes_pkg::TimeW;

	tes_pkg::state_t state_q, state_d;

	// stores
	logic [TW-1:0]                 dl_mem   [QUEUE_DEPTH];
	logic [tes_pkg::IdW-1:0]       id_mem   [QUEUE_DEPTH];
	logic [tes_pkg::ClientW-1:0]   cl_mem   [QUEUE_DEPTH];
	logic [tes_pkg::PortW-1:0]     port_mem [QUEUE_DEPTH];
	logic [tes_pkg::PeriodW-1:0]   per_mem  [QUEUE_DEPTH];
	logic [tes_pkg::CountW-1:0]    cnt_mem  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]        valid_q;
	logic [QUEUE_DEPTH-1:0]        done_q;
	logic [tes_pkg::IdW-1:0]       next_id_q;

	// latched item
	tes_pkg::func_t              func_q;
	logic [TW-1:0]               now_q, dl_in_q;
	logic [tes_pkg::PeriodW-1:0] per_in_q;
	logic [tes_pkg::CountW-1:0]  cnt_in_q;
	logic [tes_pkg::ClientW-1:0] cl_in_q;
	logic [tes_pkg::PortW-1:0]   port_in_q;
	logic [tes_pkg::IdW-1:0]     cid_q;

	logic [CW-1:0]  cnt_q;
	logic [FW-1:0]  nfire_q;
	logic [SW-1:0]  slot;
	logic [SW-1:0]  best_slot;
	logic           found;
	logic [TW-1:0]  dl_rd;
	logic           cand;
	logic           free_found_q;
	logic [SW-1:0]  free_q;
	logic [33:0]    prod_q;
	logic [TW:0]    sum;

	// output register
	logic           strobe_q, last_q;
	tes_pkg::kind_t kind_q;
	logic [31:0]    tid_q;
	logic [30:0]    fcl_q;
	logic [15:0]    fport_q;

	tes_pkg::scan_ctl_t scan_ctl;

	assign slot  = cnt_q[SW-1:0];
	assign dl_rd = dl_mem[slot];
	assign cand  = valid_q[slot] && !done_q[slot] && (dl_rd <= now_q);
	assign scan_ctl.clear = (state_q == tes_pkg::ST_IDLE) || (state_q == tes_pkg::ST_REARM);
	assign scan_ctl.step  = (state_q == tes_pkg::ST_SCAN);

	tes_scan #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.slot      (slot),
		.cand      (cand),
		.cand_dl   (dl_rd),
		.found     (found),
		.best_slot (best_slot)
	);

	assign sum = {1'b0, now_q} + {{(TW-33){1'b0}}, prod_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tes_pkg::ST_IDLE: begin
				if (start) begin
					case (tes_pkg::func_t'(func))
						tes_pkg::FUNC_CANCEL: state_d = tes_pkg::ST_CANCEL;
						tes_pkg::FUNC_TICK:   state_d = tes_pkg::ST_SCAN;
						default:              state_d = tes_pkg::ST_FIND;
					endcase
				end
			end
			tes_pkg::ST_FIND:
				if (cnt_q == CW'(QUEUE_DEPTH - 1)) state_d = tes_pkg::ST_ADD;
			tes_pkg::ST_ADD: state_d = tes_pkg::ST_DONE;
			tes_pkg::ST_CANCEL:
				if (cnt_q == CW'(QUEUE_DEPTH - 1)) state_d = tes_pkg::ST_DONE;
			tes_pkg::ST_SCAN:
				if (cnt_q == CW'(QUEUE_DEPTH - 1)) state_d = tes_pkg::ST_PICK;
			tes_pkg::ST_PICK: state_d = found ? tes_pkg::ST_FIRE : tes_pkg::ST_DONE;
			tes_pkg::ST_FIRE: state_d = tes_pkg::ST_MUL;
			tes_pkg::ST_MUL:  state_d = tes_pkg::ST_REARM;
			tes_pkg::ST_REARM:
				state_d = (nfire_q == FW'(tes_pkg::MaxFire)) ? tes_pkg::ST_DONE
				                                             : tes_pkg::ST_SCAN;
			tes_pkg::ST_DONE: state_d = tes_pkg::ST_IDLE;
			default: state_d = tes_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy = (state_q != tes_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tes_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the item
	always_ff @(posedge clk) begin
		if (state_q == tes_pkg::ST_IDLE && start) begin
			func_q    <= tes_pkg::func_t'(func);
			now_q     <= now_time;
			dl_in_q   <= deadline;
			per_in_q  <= period_ms;
			cnt_in_q  <= repeat_count;
			cl_in_q   <= client_id;
			port_in_q <= dest_port;
			cid_q     <= cancel_id;
		end
	end

	// slot counter, free slot search, fire count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			nfire_q      <= '0;
			done_q       <= '0;
		end else begin
			case (state_q)
				tes_pkg::ST_IDLE: begin
					cnt_q        <= '0;
					free_found_q <= 1'b0;
					nfire_q      <= '0;
					done_q       <= '0;
				end
				tes_pkg::ST_FIND, tes_pkg::ST_CANCEL, tes_pkg::ST_SCAN: begin
					cnt_q <= (cnt_q == CW'(QUEUE_DEPTH - 1)) ? '0 : cnt_q + 1'b1;
					if (state_q == tes_pkg::ST_FIND && !free_found_q && !valid_q[slot])
						free_found_q <= 1'b1;
				end
				tes_pkg::ST_FIRE: begin
					done_q[best_slot] <= 1'b1;
					nfire_q <= nfire_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tes_pkg::ST_FIND && !free_found_q && !valid_q[slot])
			free_q <= slot;
		// period in us; registered before the add
		if (state_q == tes_pkg::ST_FIRE)
			prod_q <= per_mem[best_slot] * tes_pkg::UsPerMs;
	end

	// valid bits and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			next_id_q <= '0;
		end else begin
			case (state_q)
				tes_pkg::ST_ADD:
					if (free_found_q) begin
						valid_q[free_q] <= 1'b1;
						next_id_q <= next_id_q + 1'b1;
					end
				tes_pkg::ST_CANCEL:
					if (valid_q[slot] && id_mem[slot] == cid_q) valid_q[slot] <= 1'b0;
				tes_pkg::ST_REARM:
					if (cnt_mem[best_slot] == '0) valid_q[best_slot] <= 1'b0;
				default: ;
			endcase
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (state_q == tes_pkg::ST_ADD && free_found_q) begin
			dl_mem[free_q]   <= (func_q == tes_pkg::FUNC_REPEAT) ? now_q : dl_in_q;
			id_mem[free_q]   <= next_id_q + 1'b1;
			cl_mem[free_q]   <= cl_in_q;
			port_mem[free_q] <= port_in_q;
			per_mem[free_q]  <= (func_q == tes_pkg::FUNC_REPEAT) ? per_in_q : '0;
			cnt_mem[free_q]  <= (func_q == tes_pkg::FUNC_REPEAT) ? cnt_in_q : '0;
		end
		if (state_q == tes_pkg::ST_REARM && cnt_mem[best_slot] != '0) begin
			cnt_mem[best_slot] <= cnt_mem[best_slot] - 1'b1;
			dl_mem[best_slot]  <= sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
		end
	end

	// result register; the last fire is flagged when the next scan finds none or the fire cap is reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				tes_pkg::ST_ADD: begin
					strobe_q <= 1'b1;
					last_q   <= 1'b1;
				end
				tes_pkg::ST_CANCEL:
					if (cnt_q == CW'(QUEUE_DEPTH - 1)) begin
						strobe_q <= 1'b1;
						last_q   <= 1'b1;
					end
				tes_pkg::ST_PICK:
					if (!found && nfire_q != '0) begin
						strobe_q <= 1'b1;
						last_q   <= 1'b1;
					end
				tes_pkg::ST_REARM:
					if (nfire_q == FW'(tes_pkg::MaxFire)) begin
						strobe_q <= 1'b1;
						last_q   <= 1'b1;
					end
				tes_pkg::ST_FIRE:
					if (nfire_q != '0) strobe_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// fired payload waits in a pending register until its last flag is known
	logic [31:0] ptid_q;
	logic [30:0] pcl_q;
	logic [15:0] pport_q;

	always_ff @(posedge clk) begin
		case (state_q)
			tes_pkg::ST_ADD: begin
				kind_q  <= free_found_q ? tes_pkg::KIND_ACCEPT : tes_pkg::KIND_REJECT;
				tid_q   <= free_found_q ? next_id_q + 1'b1 : '0;
				fcl_q   <= '0;
				fport_q <= '0;
			end
			tes_pkg::ST_CANCEL: begin
				kind_q  <= tes_pkg::KIND_CANCEL;
				tid_q   <= cid_q;
				fcl_q   <= '0;
				fport_q <= '0;
			end
			tes_pkg::ST_FIRE, tes_pkg::ST_PICK, tes_pkg::ST_REARM: begin
				kind_q  <= tes_pkg::KIND_FIRED;
				tid_q   <= ptid_q;
				fcl_q   <= pcl_q;
				fport_q <= pport_q;
			end
			default: ;
		endcase
		if (state_q == tes_pkg::ST_FIRE) begin
			ptid_q  <= id_mem[best_slot];
			pcl_q   <= cl_mem[best_slot];
			pport_q <= port_mem[best_slot];
		end
	end

	assign strobe       = strobe_q;
	assign last         = last_q;
	assign kind         = kind_q;
	assign timer_id     = tid_q;
	assign fired_client = fcl_q;
	assign fired_port   = fport_q;

	// a result never appears while idle unless it was just finished
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result without a busy item");
	// the fire count stays within the burst limit
	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nfire_q <= FW'(tes_pkg::MaxFire)) else $error("fire count overrun");
	// a started item raises busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");

endmodule
`default_nettype wire

@@ bench/timer_event_checker.sv @@
`timescale 1ns / 100ps
module timer_event_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  func,
	input  wire logic [47:0] now_time,
	input  wire logic [47:0] deadline,
	input  wire logic [23:0] period_ms,
	input  wire logic [30:0] repeat_count,
	input  wire logic [30:0] client_id,
	input  wire logic [15:0] dest_port,
	input  wire logic [31:0] cancel_id,
	input  wire logic        strobe,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] timer_id,
	input  wire logic [30:0] fired_client,
	input  wire logic [15:0] fired_port,
	input  wire logic        last,
	output int               fail_count,
	output int               pending,
	output int               fire_count,
	output int               reject_count,
	output logic [31:0]      newest_id
);

	localparam int Slots = tes_pkg::QueueDepthDefault;
	localparam logic [47:0] TimeMax = '1;

	typedef struct {
		tes_pkg::kind_t kind;
		logic [31:0]    id;
		logic [30:0]    client;
		logic [15:0]    port;
		logic           last;
	} event_t;

	// shadow copy of the timer store
	logic [47:0] due_at [Slots];
	logic [31:0] tid [Slots];
	logic [30:0] owner [Slots];
	logic [15:0] dport [Slots];
	logic [23:0] every_ms [Slots];
	logic [30:0] left [Slots];
	logic        live [Slots];
	logic [31:0] id_seq;
	event_t      event_q[$];

	task automatic report(input string what);
		fail_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic event_t mk(input tes_pkg::kind_t k, input logic [31:0] id,
		input logic [30:0] cl, input logic [15:0] pt, input logic lst);
		event_t e;
		e.kind = k; e.id = id; e.client = cl; e.port = pt; e.last = lst;
		return e;
	endfunction

	task automatic add_timer(input logic [47:0] dl, input logic [23:0] per,
		input logic [30:0] cnt, input logic [30:0] cl, input logic [15:0] pt);
		int slot;
		slot = -1;
		for (int i = 0; i < Slots; i++)
			if (!live[i] && slot < 0) slot = i;
		if (slot < 0) begin
			event_q.push_back(mk(tes_pkg::KIND_REJECT, '0, '0, '0, 1'b1));
			reject_count++;
		end else begin
			id_seq = id_seq + 32'd1;
			due_at[slot] = dl; tid[slot] = id_seq; owner[slot] = cl;
			dport[slot] = pt; every_ms[slot] = per; left[slot] = cnt;
			live[slot] = 1'b1;
			event_q.push_back(mk(tes_pkg::KIND_ACCEPT, id_seq, '0, '0, 1'b1));
		end
	endtask

	task automatic run_tick(input logic [47:0] now);
		logic fired [Slots];
		logic [63:0] nd;
		int n, best;
		n = 0;
		for (int i = 0; i < Slots; i++) fired[i] = 1'b0;
		while (n < tes_pkg::MaxFire) begin
			best = -1;
			for (int i = 0; i < Slots; i++) begin
				if (live[i] && !fired[i] && due_at[i] <= now)
					if (best < 0 || due_at[i] < due_at[best]) best = i;
			end
			if (best < 0) break;
			fired[best] = 1'b1;
			event_q.push_back(mk(tes_pkg::KIND_FIRED, tid[best], owner[best],
				dport[best], 1'b0));
			n++;
			fire_count++;
			if (left[best] != 0) begin
				nd = 64'(now) + 64'(every_ms[best]) * 64'd1000;
				left[best] = left[best] - 31'd1;
				due_at[best] = (nd > 64'(TimeMax)) ? TimeMax : nd[47:0];
			end else begin
				live[best] = 1'b0;
			end
		end
		if (n > 0) event_q[event_q.size() - 1].last = 1'b1;
	endtask

	// predict on each accepted item, compare each strobed result
	always @(posedge clk or negedge arst_n) begin
		event_t e;
		if (!arst_n) begin
			for (int i = 0; i < Slots; i++) live[i] = 1'b0;
			id_seq = '0;
			event_q.delete();
			fail_count = 0;
			fire_count = 0;
			reject_count = 0;
		end else begin
			if (strobe) begin
				if (event_q.size() == 0) begin
					report($sformatf("unexpected result kind %0d id %0d", kind, timer_id));
				end else begin
					e = event_q.pop_front();
					if (kind !== e.kind)
						report($sformatf("kind %0d, want %0d", kind, e.kind));
					if (timer_id !== e.id)
						report($sformatf("timer_id %0d, want %0d", timer_id, e.id));
					if (fired_client !== e.client)
						report($sformatf("fired_client %0h, want %0h", fired_client, e.client));
					if (fired_port !== e.port)
						report($sformatf("fired_port %0h, want %0h", fired_port, e.port));
					if (last !== e.last)
						report($sformatf("last %0b, want %0b", last, e.last));
				end
			end
			if (start && !busy) begin
				case (tes_pkg::func_t'(func))
					tes_pkg::FUNC_ONESHOT: add_timer(deadline, '0, '0, client_id, dest_port);
					tes_pkg::FUNC_REPEAT:  add_timer(now_time, period_ms, repeat_count,
						client_id, dest_port);
					tes_pkg::FUNC_CANCEL: begin
						for (int i = 0; i < Slots; i++)
							if (live[i] && tid[i] == cancel_id) live[i] = 1'b0;
						event_q.push_back(mk(tes_pkg::KIND_CANCEL, cancel_id, '0, '0, 1'b1));
					end
					default: run_tick(now_time);
				endcase
			end
		end
		pending = event_q.size();
		newest_id = id_seq;
	end

endmodule

@@ bench/timer_event_scheduler_top_test.sv @@
`timescale 1ns / 100ps
module timer_event_scheduler_top_test;

	localparam int CycleLimit = 2000000;
	localparam int RandomItems = 380;
	localparam logic [47:0] TimeMax = '1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = tes_pkg::FUNC_TICK;
	logic [47:0] now_time = '0;
	logic [47:0] deadline = '0;
	logic [23:0] period_ms = '0;
	logic [30:0] repeat_count = '0;
	logic [30:0] client_id = '0;
	logic [15:0] dest_port = '0;
	logic [31:0] cancel_id = '0;
	logic        strobe;
	logic [1:0]  kind;
	logic [31:0] timer_id;
	logic [30:0] fired_client;
	logic [15:0] fired_port;
	logic        last;

	int          fail_count, pending, fire_count, reject_count;
	logic [31:0] newest_id;
	int          cycles = 0;
	int          items_sent = 0;
	logic [47:0] clock_us = 48'd1000;

	always #5 clk = ~clk;

	timer_event_scheduler_top u_top (.*);

	timer_event_checker u_checker (.*);

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// present one item and hold it until the block takes it
	task automatic send(input tes_pkg::func_t f, input logic [47:0] now,
		input logic [47:0] dl, input logic [23:0] per, input logic [30:0] cnt,
		input logic [31:0] cid);
		func <= f;
		now_time <= now;
		deadline <= dl;
		period_ms <= per;
		repeat_count <= cnt;
		client_id <= 31'($urandom);
		dest_port <= 16'($urandom);
		cancel_id <= cid;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// idle the command side for a while, mostly briefly
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) :
			(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4));
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	initial begin
		int pick;
		logic [31:0] cid;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: quiet tick, fill the store, reject, cancel, burst tick
		send(tes_pkg::FUNC_TICK, 48'd0, '0, '0, '0, '0);
		send(tes_pkg::FUNC_ONESHOT, '0, TimeMax, '0, '0, '0);
		send(tes_pkg::FUNC_ONESHOT, '0, 48'd0, '0, '0, '0);
		send(tes_pkg::FUNC_REPEAT, 48'd500, '0, 24'd0, 31'd2, '0);
		send(tes_pkg::FUNC_REPEAT, TimeMax - 48'd500, '0, '1, 31'd1, '0);
		send(tes_pkg::FUNC_REPEAT, 48'd700, '0, 24'd3, '1, '0);
		for (int i = 0; i < 12; i++)
			send(tes_pkg::FUNC_ONESHOT, '0, 48'd800, '0, '0, '0);
		send(tes_pkg::FUNC_ONESHOT, '0, 48'd800, '0, '0, '0);
		send(tes_pkg::FUNC_CANCEL, '0, '0, '0, '0, 32'd5);
		send(tes_pkg::FUNC_CANCEL, '0, '0, '0, '0, '1);
		send(tes_pkg::FUNC_TICK, 48'd1000, '0, '0, '0, '0);
		send(tes_pkg::FUNC_TICK, 48'd1000, '0, '0, '0, '0);
		send(tes_pkg::FUNC_TICK, TimeMax, '0, '0, '0, '0);
		send(tes_pkg::FUNC_TICK, TimeMax, '0, '0, '0, '0);
		send(tes_pkg::FUNC_CANCEL, '0, '0, '0, '0, 32'd5);
		send(tes_pkg::FUNC_CANCEL, '0, '0, '0, '0, 32'd2);
		drain();

		// random: mostly near-term timers against an advancing clock
		for (int k = 0; k < RandomItems; k++) begin
			idle_gap();
			if (k == RandomItems / 2) drain();
			clock_us = clock_us + 48'($urandom_range(0, 3000));
			pick = $urandom_range(0, 99);
			cid = newest_id - 32'($urandom_range(0, 12));
			if ($urandom_range(0, 19) == 0) cid = $urandom;
			if (pick < 35)
				send(tes_pkg::FUNC_ONESHOT, 48'({$urandom, $urandom}),
					($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) :
					clock_us + 48'($urandom_range(0, 8000)), 24'($urandom),
					31'($urandom), $urandom);
			else if (pick < 55)
				send(tes_pkg::FUNC_REPEAT, clock_us, 48'({$urandom, $urandom}),
					($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4)),
					($urandom_range(0, 19) == 0) ? 31'($urandom) : 31'($urandom_range(0, 3)),
					$urandom);
			else if (pick < 70)
				send(tes_pkg::FUNC_CANCEL, 48'({$urandom, $urandom}),
					48'({$urandom, $urandom}), 24'($urandom), 31'($urandom), cid);
			else
				send(tes_pkg::FUNC_TICK,
					($urandom_range(0, 29) == 0) ? 48'({$urandom, $urandom}) : clock_us,
					48'({$urandom, $urandom}), 24'($urandom), 31'($urandom), $urandom);
		end

		// wait out the tail, then give the verdict
		drain();
		repeat (400) @(posedge clk);
		$display("Ran %0d items: %0d timers fired, %0d requests rejected on a full store.",
			items_sent, fire_count, reject_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results never seen", fail_count, pending);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
